// ===== hdl/tws_pkg.sv =====
package tws_pkg;

	// default table sizes
	localparam int NODE_COUNT_DEF = 1024;
	localparam int ALPHABET_DEF   = 26;
	localparam int LETTER_W       = 5;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND   = 1'b1;

	// result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	// one input item
	typedef struct packed {
		logic                command;
		logic [LETTER_W-1:0] letter;
		logic                has_letter;
		logic                last;
	} item_t;

	// one result item
	typedef struct packed {
		logic found;
		logic status;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_STEP,
		ST_FIN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic clear;
		logic look;
		logic step;
		logic fin;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_walk;
		logic item_last;
		logic clear_last;
	} sts_t;

endpackage

// ===== hdl/tws_ctrl.sv =====
module tws_ctrl
	import tws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	state_t state_q;
	state_t state_d;

	// state register, clearing pass runs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.accept = 1'b1;
					if (sts.needs_walk) begin
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				ctl.look = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				ctl.step = 1'b1;
				state_d  = sts.item_last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				ctl.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/tws_datapath.sv =====
module tws_datapath
	import tws_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int ALPHABET   = ALPHABET_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl,
	input  item_t   item,
	output sts_t    sts,
	output logic    done,
	output result_t result
);

	localparam int NW    = $clog2(NODE_COUNT);
	localparam int SLOTS = NODE_COUNT * ALPHABET;
	localparam int AW    = $clog2(SLOTS);
	localparam int FW    = NW + 1;

	// node store
	logic [NW-1:0] child_mem [SLOTS];
	logic          end_mem   [NODE_COUNT];

	// walk state
	item_t         item_q;
	logic [NW-1:0] cursor_q;
	logic [FW-1:0] next_free_q;
	logic          miss_q;
	logic          full_q;
	logic          root_end_q;
	logic [AW-1:0] clr_cnt_q;
	logic [NW-1:0] child_s1;
	logic          end_rd_q;
	logic          done_q;
	result_t       result_q;

	logic          code_ok;
	logic          needs_walk;
	logic [AW-1:0] slot_addr;
	logic [NW-1:0] cursor_w;
	logic [NW-1:0] cursor_d;
	logic [FW-1:0] next_free_d;
	logic          miss_w;
	logic          full_w;
	logic          alloc;
	logic          fin_now;
	logic          fin_find;
	logic          cur_end;
	logic          set_end;
	result_t       result_d;

	// letter check on the incoming item
	assign code_ok    = int'(item.letter) < ALPHABET;
	assign needs_walk = item.has_letter & ~miss_q & ~full_q & code_ok;
	assign slot_addr  = AW'(cursor_q) * AW'(ALPHABET) + AW'(item_q.letter);

	assign sts.needs_walk = needs_walk;
	assign sts.item_last  = item_q.last;
	assign sts.clear_last = (clr_cnt_q == AW'(SLOTS - 1));

	// one walk step, then end-of-word handling
	always_comb begin
		cursor_w    = cursor_q;
		next_free_d = next_free_q;
		miss_w      = miss_q;
		full_w      = full_q;
		alloc       = 1'b0;
		if (ctl.accept && !needs_walk) begin
			miss_w = miss_q | (item.has_letter & ~full_q & ~code_ok);
		end
		if (ctl.step) begin
			if (child_s1 != '0) begin
				cursor_w = child_s1;
			end else if (item_q.command == CMD_FIND) begin
				miss_w = 1'b1;
			end else if (next_free_q == FW'(NODE_COUNT)) begin
				full_w = 1'b1;
			end else begin
				alloc       = 1'b1;
				cursor_w    = NW'(next_free_q);
				next_free_d = next_free_q + 1'b1;
			end
		end

		fin_now  = (ctl.accept & ~needs_walk & item.last) | ctl.fin;
		fin_find = ctl.fin ? (item_q.command == CMD_FIND) : (item.command == CMD_FIND);
		cur_end  = (cursor_q == '0) ? root_end_q : end_rd_q;
		set_end  = ~fin_find & ~miss_w & ~full_w;

		result_d.found  = fin_find & ~miss_w & ~full_w & cur_end;
		result_d.status = (~fin_find & (miss_w | full_w)) ? STATUS_ERROR : STATUS_OK;

		cursor_d = fin_now ? '0 : cursor_w;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			next_free_q <= FW'(1);
			miss_q      <= 1'b0;
			full_q      <= 1'b0;
			root_end_q  <= 1'b0;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			cursor_q    <= cursor_d;
			next_free_q <= next_free_d;
			miss_q      <= fin_now ? 1'b0 : miss_w;
			full_q      <= fin_now ? 1'b0 : full_w;
			done_q      <= fin_now;
			if (fin_now && set_end && cursor_q == '0) begin
				root_end_q <= 1'b1;
			end
			if (ctl.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			item_q <= item;
		end
		if (fin_now) begin
			result_q <= result_d;
		end
	end

	// child table: clearing sweep, allocation write, lookup read
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			child_mem[clr_cnt_q] <= '0;
		end else if (alloc) begin
			child_mem[slot_addr] <= NW'(next_free_q);
		end
		if (ctl.look) begin
			child_s1 <= child_mem[slot_addr];
		end
	end

	// end marks: clearing sweep, mark write, read at the next cursor
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			if (clr_cnt_q < AW'(NODE_COUNT)) begin
				end_mem[clr_cnt_q[NW-1:0]] <= 1'b0;
			end
		end else if (fin_now && set_end && cursor_q != '0) begin
			end_mem[cursor_q] <= 1'b1;
		end
		end_rd_q <= end_mem[cursor_d];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/trie_word_store.sv =====
// a result strobes in the cycle after its last item's work ends
// item without a walk step (no letter, stopped walk, bad letter): accept only
// letter item: accept, child-table read, step; last letter: accept, read, step, finish
// the child table read is registered; each letter's read needs the previous cursor
// reset: a clearing pass over all NODE_COUNT*ALPHABET child slots runs with busy high
// the receiver cannot stall: done is high for exactly one cycle per result
module trie_word_store
	import tws_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int ALPHABET   = ALPHABET_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	ctl_t ctl;
	sts_t sts;

	// sequencer
	tws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// node store and walk state
	tws_datapath #(
		.NODE_COUNT (NODE_COUNT),
		.ALPHABET   (ALPHABET)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

`ifndef SYNTHESIS
	// a step always follows its lookup read
	a_step_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> $past(ctl.look))
		else $error("step without a preceding lookup");

	// finishing a walked word strobes a result next cycle
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> done)
		else $error("finish without result strobe");

	// a result never reports both a hit and an error
	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.status == STATUS_ERROR))
		else $error("result with found and error");

	// no transfer is taken while busy
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> (start && !busy))
		else $error("transfer taken while busy");
`endif

endmodule
